[hdl/aesctr_pkg.sv]
package aesctr_pkg;

	typedef enum logic [1:0] {
		CMD_KEY  = 2'd0,
		CMD_CTR  = 2'd1,
		CMD_DATA = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [4:0]  word_index;
		logic [63:0] word_value;
		logic [7:0]  data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [3:0] position_after;
	} out_item_t;

	// item passed from the front to the back through the queue
	typedef struct packed {
		logic       refill;
		logic [3:0] pos;
		logic [7:0] data_byte;
	} job_t;

	localparam logic [3:0] ROUNDS_10 = 4'd10;
	localparam logic [3:0] ROUNDS_12 = 4'd12;
	localparam logic [3:0] ROUNDS_14 = 4'd14;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[a];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// byte i of the state sits at bits 127-8i
	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[127-8*(4*c+r) -: 8] = sbox(s[127-8*(4*((c+r)%4)+r) -: 8]);
		return t;
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0]   a0, a1, a2, a3, al;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127-32*c -: 8];
			a1 = s[119-32*c -: 8];
			a2 = s[111-32*c -: 8];
			a3 = s[103-32*c -: 8];
			al = a0 ^ a1 ^ a2 ^ a3;
			t[127-32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
			t[119-32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
			t[111-32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
			t[103-32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
		end
		return t;
	endfunction

endpackage

[hdl/aesctr_front.sv]
module aesctr_front
	import aesctr_pkg::*;
#(
	parameter int ROUND_KEYS = 15
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  in_item_t in_item,
	input  logic     accept,
	output logic     is_data,
	output job_t     job,
	output logic     key_we,
	output logic [$clog2(2*ROUND_KEYS)-1:0] key_addr,
	output logic     ctr_we,
	output logic     ctr_sel,
	output logic [63:0] ctr_value
);
	localparam int KW = 2 * ROUND_KEYS;
	localparam int AW = $clog2(KW);

	logic [3:0] pos_q;
	logic       do_acc;

	assign do_acc    = in_valid && accept;
	assign is_data   = (in_item.command == CMD_DATA);
	assign key_we    = do_acc && (in_item.command == CMD_KEY)
		&& ({27'd0, in_item.word_index} < KW);
	assign key_addr  = in_item.word_index[AW-1:0];
	assign ctr_we    = do_acc && (in_item.command == CMD_CTR)
		&& (in_item.word_index[4:1] == 4'd0);
	assign ctr_sel   = in_item.word_index[0];
	assign ctr_value = in_item.word_value;

	assign job.refill    = (pos_q == 4'd0);
	assign job.pos       = pos_q;
	assign job.data_byte = in_item.data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (ctr_we) begin
			pos_q <= '0;
		end else if (do_acc && is_data) begin
			pos_q <= pos_q + 4'd1;
		end
	end
endmodule

[hdl/aesctr_back.sv]
module aesctr_back
	import aesctr_pkg::*;
#(
	parameter int ROUND_KEYS = 15
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic [3:0] round_count,
	input  logic      key_we,
	input  logic [$clog2(2*ROUND_KEYS)-1:0] key_addr,
	input  logic [63:0] key_value,
	input  logic [127:0] counter,
	output logic      ctr_inc,
	input  logic      q_valid,
	input  job_t      q_job,
	output logic      q_pop,
	output logic      out_valid,
	output out_item_t out_item,
	input  logic      out_stall
);
	localparam int KW = 2 * ROUND_KEYS;
	localparam int AW = $clog2(KW);

	logic [63:0]  key_mem [KW];
	logic [63:0]  rd_q;
	logic [AW-1:0] rd_addr;

	logic [3:0]   nr;
	logic         busy_q;
	logic         ks_ok_q;  // keystream for the refill request at the head is ready
	logic [4:0]   step_q;   // key word being read
	logic [3:0]   rnd_q;    // round whose key is being applied
	logic         half_q;
	logic         hi_valid_q;
	logic [63:0]  hi_q;
	logic [127:0] st_q;
	logic [127:0] ks_q;
	logic         ov_q;
	out_item_t    oi_q;
	logic         can_out;
	logic [127:0] rk, st_next;
	logic [7:0]   ksb;

	always_comb begin
		nr = ROUNDS_10;
		if ((round_count == ROUNDS_12 || round_count == ROUNDS_14)
			&& ({28'd0, round_count} + 32'd1 <= ROUND_KEYS))
			nr = round_count;
	end

	// key words are read one per cycle, high half then low half; word 0 is read while idle
	assign rd_addr = busy_q ? step_q[AW-1:0] : '0;

	always_ff @(posedge clk) begin
		if (key_we)
			key_mem[key_addr] <= key_value;
		rd_q <= key_mem[rd_addr];
	end

	assign rk = {hi_q, rd_q};
	always_comb begin
		if (rnd_q == 4'd0)
			st_next = counter ^ rk;
		else if (rnd_q == nr)
			st_next = sub_shift(st_q) ^ rk;
		else
			st_next = mix_columns(sub_shift(st_q)) ^ rk;
	end

	assign can_out = !ov_q || !out_stall;
	assign ksb = ks_q[127-8*q_job.pos[3:0] -: 8];
	assign q_pop = q_valid && !busy_q && (!q_job.refill || ks_ok_q) && can_out;
	assign ctr_inc = busy_q && half_q && rnd_q == nr && hi_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			ks_ok_q    <= 1'b0;
			step_q     <= '0;
			rnd_q      <= '0;
			half_q     <= 1'b0;
			hi_valid_q <= 1'b0;
			ks_q       <= '0;
			ov_q       <= 1'b0;
		end else begin
			if (ov_q && !out_stall)
				ov_q <= 1'b0;
			if (!busy_q) begin
				if (q_valid && q_job.refill && !ks_ok_q) begin
					busy_q     <= 1'b1;
					step_q     <= 5'd1;
					rnd_q      <= '0;
					half_q     <= 1'b0;
					hi_valid_q <= 1'b0;
				end else if (q_pop) begin
					ov_q    <= 1'b1;
					ks_ok_q <= 1'b0;
				end
			end else begin
				// rd_q holds word step_q-1
				step_q <= step_q + 5'd1;
				half_q <= ~half_q;
				if (!half_q) begin
					hi_valid_q <= 1'b1;
				end else if (hi_valid_q) begin
					if (rnd_q == nr) begin
						ks_q    <= st_next;
						busy_q  <= 1'b0;
						ks_ok_q <= 1'b1;
					end
					rnd_q <= rnd_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !half_q)
			hi_q <= rd_q;
		if (busy_q && half_q && hi_valid_q)
			st_q <= st_next;
		if (q_pop) begin
			oi_q.out_byte       <= q_job.data_byte ^ ksb;
			oi_q.position_after <= q_job.pos + 4'd1;
		end
	end

	assign out_valid = ov_q;
	assign out_item  = oi_q;
endmodule

[hdl/aes_ctr_byte_stream_cipher.sv]
// bytes 1..15 of a block are registered in the queue and then in the output register; byte 0
// also waits for the keystream refill, which reads one key memory word per cycle
// throughput: one byte per cycle inside a block while out_stall is low; the first byte of
// each block of 16 bytes also waits for the keystream refill
// loads wait until the 2-entry queue between front and back is empty
// reset: counter, position, keystream and round count (10) clear; key store is not
module aes_ctr_byte_stream_cipher
	import aesctr_pkg::*;
#(
	parameter int ROUND_KEYS = 15
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [3:0] cfg_data,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);
	localparam int AW = $clog2(2 * ROUND_KEYS);

	logic [3:0]  rc_q;
	logic [63:0] ctr_hi_q, ctr_lo_q;
	logic        is_data, key_we, ctr_we, ctr_sel, ctr_inc, q_pop;
	logic [AW-1:0] key_addr;
	logic [63:0] ctr_value;
	job_t        job;
	job_t        q_mem_q [2];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	logic        q_full, push, accept, is_load;

	assign cfg_ready = 1'b1;
	assign q_full    = (cnt_q == 2'd2);
	assign is_load   = in_item.command inside {CMD_KEY, CMD_CTR};
	// a load waits until no data request is queued, so no refill is running
	assign in_stall  = is_data ? q_full : (is_load && (cnt_q != 2'd0));
	assign accept    = !in_stall;
	assign push      = in_valid && accept && is_data;

	aesctr_front #(.ROUND_KEYS(ROUND_KEYS)) u_front (
		.clk, .arst_n, .in_valid, .in_item, .accept, .is_data, .job,
		.key_we, .key_addr, .ctr_we, .ctr_sel, .ctr_value
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q     <= ROUNDS_10;
			ctr_hi_q <= '0;
			ctr_lo_q <= '0;
			wp_q     <= 1'b0;
			rp_q     <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (cfg_valid)
				rc_q <= cfg_data;
			// counter loads are held off while the queue is busy, so they never meet a refill
			if (ctr_we && !ctr_sel)
				ctr_hi_q <= ctr_value;
			if (ctr_we && ctr_sel)
				ctr_lo_q <= ctr_value;
			else if (ctr_inc)
				ctr_lo_q <= ctr_lo_q + 64'd1;
			if (push)
				wp_q <= ~wp_q;
			if (q_pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			q_mem_q[wp_q] <= job;
	end

	aesctr_back #(.ROUND_KEYS(ROUND_KEYS)) u_back (
		.clk, .arst_n, .round_count(rc_q), .key_we, .key_addr,
		.key_value(in_item.word_value), .counter({ctr_hi_q, ctr_lo_q}), .ctr_inc,
		.q_valid(cnt_q != 2'd0), .q_job(q_mem_q[rp_q]), .q_pop,
		.out_valid, .out_item, .out_stall
	);
endmodule
